// ===== sv/range_increment_mod3_count_tree_macros.svh =====
// Assertion macros for the range increment / mod-3 count tree.
`ifndef RANGE_INCREMENT_MOD3_COUNT_TREE_MACROS_SVH
`define RANGE_INCREMENT_MOD3_COUNT_TREE_MACROS_SVH
`ifndef SYNTHESIS
`define RIM_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("label");
`define RIM_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("label");
`else
`define RIM_ASSERT_IMP(label, clk, rst, a, c)
`define RIM_ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

// ===== sv/rim3_pkg.sv =====
// Package: shared types and constants of the mod-3 count tree.
package rim3_pkg;
  localparam int unsigned FieldW = 10;
  localparam int unsigned CountW = 11;
  localparam logic MODE_INC = 1'b0;
  localparam logic MODE_QRY = 1'b1;
  typedef struct packed {
    logic              mode;
    logic [FieldW-1:0] range_lo;
    logic [FieldW-1:0] range_hi;
  } rim3_req_t;
  typedef struct packed {
    logic [CountW-1:0] count_divisible;
  } rim3_rsp_t;
endpackage

// ===== sv/rim3_stream_if.sv =====
// Valid/ready stream interface carrying one payload type.
interface rim3_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== sv/rim3_ram.sv =====
// Generic single-port RAM with registered read.
module rim3_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

// ===== sv/range_increment_mod3_count_tree.sv =====
// Top level: range increment and count of multiples of three over a counter array.
//
// Usage:
//   req (sink): mode, range_lo, range_hi. mode 0 adds one to every element of
//   the inclusive range; mode 1 returns how many elements of it are multiples
//   of three on rsp. Increments give no result.
//   Config (APB): register 0 at address 0 is elements_in_use (0..CAPACITY,
//   taken from bits 10:0; larger values saturate). Writing it clears all counters.
//   Implementation: one counter residue per element, in a RAM of CAPACITY
//   2-bit words, swept over the clamped range with a read state and a
//   read-modify-write state per element.
//   Throughput: one item at a time; a query result sits in an output
//   register while the receiver stalls. Increments are still taken while it
//   waits; a query is taken only once the previous result has been taken.
//   Reset and register writes run a clearing pass over all CAPACITY words,
//   during which no item is accepted.
module range_increment_mod3_count_tree
  import rim3_pkg::*;
#(
  parameter int unsigned CAPACITY = 1024
) (
  input  logic        clk,
  input  logic        rst,
  rim3_stream_if.sink   req,
  rim3_stream_if.source rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  `include "range_increment_mod3_count_tree_macros.svh"

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned NW = $clog2(CAPACITY + 1);
  localparam int unsigned XW = ((NW > FieldW) ? NW : FieldW) + 1;
  localparam logic [2:0] REG_ELEMS = 3'd0;

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_READ, S_RMW, S_DONE} state_t;

  state_t            state;
  logic [NW-1:0]     elems;
  logic [AW-1:0]     cur;
  logic [AW-1:0]     last;
  logic              mode;
  logic [CountW-1:0] acc;
  logic              rsp_valid;
  logic [CountW-1:0] rsp_count;
  logic              ram_we;
  logic [AW-1:0]     ram_addr;
  logic [1:0]        ram_wdata;
  logic [1:0]        ram_rdata;
  logic              cfg_wr;
  logic [NW-1:0]     cfg_val;
  logic [10:0]       wv;
  logic [XW-1:0]     lo_x;
  logic [XW-1:0]     hi_x;
  logic [XW-1:0]     hi_c;
  logic              empty;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_ELEMS) ? 32'(elems) : 32'd0;
  assign cfg_wr = psel && penable && pwrite && (paddr == REG_ELEMS);
  assign wv     = pwdata[10:0];
  assign cfg_val = ((NW+11)'(wv) > (NW+11)'(CAPACITY)) ? NW'(CAPACITY) : NW'(wv);

  // clamp the incoming range
  assign lo_x  = XW'(req.data.range_lo);
  assign hi_x  = XW'(req.data.range_hi);
  assign hi_c  = (hi_x > XW'(elems) - 1'b1) ? XW'(elems) - 1'b1 : hi_x;
  assign empty = (elems == '0) || (lo_x > hi_c);

  assign req.ready = (state == S_IDLE) && !cfg_wr &&
                     !(rsp_valid && req.data.mode == MODE_QRY);
  assign rsp.valid = rsp_valid;
  assign rsp.data.count_divisible = rsp_count;

  // memory port
  always_comb begin
    ram_we    = (state == S_CLEAR) || (state == S_RMW && mode == MODE_INC);
    ram_addr  = cur;
    ram_wdata = (state == S_CLEAR) ? 2'd0 : ((ram_rdata == 2'd2) ? 2'd0 : ram_rdata + 2'd1);
  end

  rim3_ram #(.WIDTH(2), .DEPTH(CAPACITY)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      elems     <= NW'((CAPACITY > 1024) ? 1024 : CAPACITY);
      cur       <= '0;
      rsp_valid <= 1'b0;
      acc       <= '0;
    end else begin
      if (rsp_valid && rsp.ready) rsp_valid <= 1'b0;
      if (cfg_wr) begin
        elems <= cfg_val;
        state <= S_CLEAR;
        cur   <= '0;
      end else begin
        unique case (state)
          S_CLEAR: begin
            cur <= cur + 1'b1;
            if (cur == AW'(CAPACITY - 1)) begin
              state <= S_IDLE;
              cur   <= '0;
            end
          end
          S_IDLE: begin
            if (req.valid && req.ready) begin
              mode <= req.data.mode;
              acc  <= '0;
              cur  <= AW'(req.data.range_lo);
              last <= hi_c[AW-1:0];
              state <= empty ? S_DONE : S_READ;
            end
          end
          S_READ: state <= S_RMW;
          S_RMW: begin
            if (ram_rdata == 2'd0) acc <= acc + 1'b1;
            if (cur == last) state <= S_DONE;
            else begin
              cur   <= cur + 1'b1;
              state <= S_READ;
            end
          end
          S_DONE: begin
            if (mode == MODE_QRY) begin
              rsp_valid <= 1'b1;
              rsp_count <= acc;
            end
            state <= S_IDLE;
          end
          default: state <= S_CLEAR;
        endcase
      end
    end
  end

  `RIM_ASSERT_IMP(a_no_accept_busy, clk, rst, req.valid && req.ready, state == S_IDLE)
  `RIM_ASSERT_NEXT(a_write_clears, clk, rst, cfg_wr, state == S_CLEAR)
  `RIM_ASSERT_IMP(a_rsp_hold, clk, rst, rsp_valid && !rsp.ready && state == S_DONE, mode == MODE_INC)
  `RIM_ASSERT_IMP(a_sweep_bound, clk, rst, state == S_RMW, cur <= last)
endmodule
